// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PSFP_ASSERT(LBL, CLK, RSTN, PROP) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
    else $error("psfp assertion failed");

// Clocked assertion that is also checked during reset.
`define PSFP_ASSERT_NR(LBL, CLK, PROP) \
  LBL: assert property (@(posedge CLK) PROP) \
    else $error("psfp assertion failed");

`endif

// File: rtl/psfp_pkg.sv
package psfp_pkg;

  // Fixed field widths of the serial byte and of the result words.
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int WORD_IDX_W  = 4;

  // Byte that opens every frame.
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h42;

  // Completed frame as handed from the parser to the read-out side.
  typedef struct packed {
    logic bank;
    logic ok;
  } desc_t;

  // Push of a completed frame into the queue.
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } frame_done_t;

  // Read-out side hands a buffer bank back to the parser.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // One result word as held in the output buffer.
  typedef struct packed {
    logic [WORD_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]     word_value;
    logic                  checksum_ok;
    logic                  last;
  } out_item_t;

endpackage

// File: rtl/psfp_ifs.sv
// Byte request channel from the serial receiver.
interface psfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [psfp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result word request channel.
interface psfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [psfp_pkg::WORD_IDX_W-1:0] word_index;
  logic [psfp_pkg::WORD_W-1:0]     word_value;
  logic                            checksum_ok;
  logic                            last;

  modport source (output valid, output word_index, output word_value,
                  output checksum_ok, output last, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input checksum_ok, input last, output ready);
endinterface

// File: rtl/psfp_ram.sv
module psfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/psfp_front.sv
module psfp_front #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psfp_pkg::BYTE_W-1:0]       rx_byte,
  output logic                              ram_we,
  output logic [((FRAME_BYTES-4)/2 > 1 ? $clog2((FRAME_BYTES-4)/2) : 1):0] ram_waddr,
  output logic [psfp_pkg::WORD_W-1:0]       ram_wdata,
  output psfp_pkg::frame_done_t             done,
  input  psfp_pkg::release_t                rel
);

  localparam int DATA_WORDS = (FRAME_BYTES - 4) / 2;
  localparam int IDX_W      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int POS_W      = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CHK_POS  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] WORD_END = POS_W'(2 + 2 * DATA_WORDS);
  localparam logic [POS_W-1:0] FIRST_WD = POS_W'(2);

  logic                          in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [psfp_pkg::WORD_W-1:0]   sum_r, sum_nxt;
  logic [psfp_pkg::BYTE_W-1:0]   hold_r, hold_nxt;
  logic                          bank_r, bank_nxt;
  logic [1:0]                    busy_r, busy_nxt;

  logic                          accept;
  logic [POS_W-1:0]              offset;
  logic                          in_words;
  logic [psfp_pkg::WORD_W-1:0]   check_word;

  // A frame may only proceed while its buffer bank is not still being read out.
  assign in_ready = !in_frame_r || !busy_r[bank_r];
  assign accept   = in_valid && in_ready;

  assign offset     = pos_r - FIRST_WD;
  assign in_words   = (pos_r >= FIRST_WD) && (pos_r < WORD_END);
  assign check_word = {hold_r, rx_byte};

  // Frame parsing: start hunt, running sum, word packing, frame completion and bank release.
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    hold_nxt     = hold_r;
    bank_nxt     = bank_r;
    busy_nxt     = busy_r;
    ram_we       = 1'b0;
    ram_waddr    = {bank_r, IDX_W'(offset >> 1)};
    ram_wdata    = check_word;
    done         = '0;
    done.desc.bank = bank_r;
    done.desc.ok   = (sum_r == check_word);

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == psfp_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_W'(1);
          sum_nxt      = {8'h00, rx_byte};
        end
      end else begin
        if (pos_r < CHK_POS) begin
          sum_nxt = sum_r + {8'h00, rx_byte};
        end
        if (in_words && !offset[0]) begin
          hold_nxt = rx_byte;
        end
        if (in_words && offset[0]) begin
          ram_we = 1'b1;
        end
        if (pos_r == CHK_POS) begin
          hold_nxt = rx_byte;
        end
        if (pos_r == LAST_POS) begin
          done.valid       = 1'b1;
          busy_nxt[bank_r] = 1'b1;
          bank_nxt         = !bank_r;
          in_frame_nxt     = 1'b0;
          pos_nxt          = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
      hold_r     <= '0;
      bank_r     <= 1'b0;
      busy_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      hold_r     <= hold_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

// File: rtl/psfp_queue.sv
module psfp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psfp_pkg::frame_done_t push,
  input  logic                  pop,
  output logic                  head_valid,
  output psfp_pkg::desc_t       head
);

  psfp_pkg::desc_t ent_r [2];
  psfp_pkg::desc_t ent_nxt [2];
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0]      cnt_left;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[0];

  // Two-entry queue; the head always sits in the first entry.
  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    cnt_left   = cnt_r - {1'b0, pop && head_valid};
    if (pop && head_valid) begin
      ent_nxt[0] = ent_r[1];
    end
    cnt_nxt = cnt_left;
    if (push.valid && (cnt_left != 2'd2)) begin
      if (cnt_left == 2'd0) begin
        ent_nxt[0] = push.desc;
      end else begin
        ent_nxt[1] = push.desc;
      end
      cnt_nxt = cnt_left + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

endmodule

// File: rtl/psfp_back.sv
module psfp_back #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  psfp_pkg::desc_t                 head,
  output logic                            pop,
  output psfp_pkg::release_t              rel,
  output logic                            ram_re,
  output logic [((FRAME_BYTES-4)/2 > 1 ? $clog2((FRAME_BYTES-4)/2) : 1):0] ram_raddr,
  input  logic [psfp_pkg::WORD_W-1:0]     ram_rdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output psfp_pkg::out_item_t             out_item
);

  localparam int DATA_WORDS = (FRAME_BYTES - 4) / 2;
  localparam int IDX_W      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_WORDS - 1);

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                infl_r;
  logic [IDX_W-1:0]    infl_idx_r;
  logic                infl_ok_r;
  logic                infl_last_r;
  psfp_pkg::out_item_t buf_r [2];
  psfp_pkg::out_item_t buf_nxt [2];
  logic [1:0]          occ_r, occ_nxt, occ_left;

  logic                take;
  logic                last_word;
  logic [IDX_W+3:0]    idx_wide;
  psfp_pkg::out_item_t incoming;

  assign out_valid = (occ_r != 2'd0);
  assign out_item  = buf_r[0];
  assign take      = out_valid && out_ready;

  // Issue a read whenever the output buffer is sure to have room for its data.
  assign ram_re    = head_valid && ((occ_r + {1'b0, infl_r} <= 2'd1) || take);
  assign ram_raddr = {head.bank, idx_r};
  assign last_word = (idx_r == LAST_IDX);
  assign pop       = ram_re && last_word;
  assign rel.valid = pop;
  assign rel.bank  = head.bank;

  always_comb begin
    idx_nxt = idx_r;
    if (ram_re) begin
      idx_nxt = last_word ? '0 : idx_r + IDX_W'(1);
    end
  end

  // Read data returns in the cycle after issue; the index is reduced to four bits.
  assign idx_wide = {4'b0000, infl_idx_r};
  always_comb begin
    incoming.word_index  = idx_wide[3:0];
    incoming.word_value  = ram_rdata;
    incoming.checksum_ok = infl_ok_r;
    incoming.last        = infl_last_r;
  end

  // Two-entry output buffer; the head is always the first entry.
  always_comb begin
    buf_nxt[0] = buf_r[0];
    buf_nxt[1] = buf_r[1];
    occ_left   = occ_r - {1'b0, take};
    if (take) begin
      buf_nxt[0] = buf_r[1];
    end
    occ_nxt = occ_left;
    if (infl_r) begin
      if (occ_left == 2'd0) begin
        buf_nxt[0] = incoming;
      end else begin
        buf_nxt[1] = incoming;
      end
      occ_nxt = occ_left + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      infl_r <= 1'b0;
      occ_r  <= '0;
    end else begin
      idx_r  <= idx_nxt;
      infl_r <= ram_re;
      occ_r  <= occ_nxt;
    end
    infl_idx_r  <= idx_r;
    infl_ok_r   <= head.ok;
    infl_last_r <= last_word;
    buf_r[0]    <= buf_nxt[0];
    buf_r[1]    <= buf_nxt[1];
  end

endmodule

// File: rtl/particle_sensor_frame_parser_top.sv
// Particle-sensor frame parser. One received byte is taken per clock cycle.
// Bytes are dropped until 0x42 starts a frame of FRAME_BYTES bytes; on the
// last byte of the frame the (FRAME_BYTES-4)/2 data words are sent out, one
// per cycle while the sink is ready, each flagged with whether the 16-bit
// byte sum matched the frame's checksum word, the final one marked last.
// When the read-out side is idle, the first word is offered once the frame
// has passed the queue, the memory read and the output buffer. Words are
// held in a two-bank buffer memory, so a frame can be received while the
// previous one is read out; the input stalls only when a third frame
// reaches its second byte while both banks hold frames still unread.
module particle_sensor_frame_parser_top #(
  parameter int FRAME_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  psfp_in_if.sink            in_ch,
  psfp_out_if.source         out_ch
);

  localparam int DATA_WORDS = (FRAME_BYTES - 4) / 2;
  localparam int IDX_W      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int ADDR_W     = IDX_W + 1;

  logic                          front_ready;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [psfp_pkg::WORD_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [psfp_pkg::WORD_W-1:0]   ram_rdata;
  psfp_pkg::frame_done_t         done;
  psfp_pkg::release_t            rel;
  logic                          q_pop;
  logic                          q_valid;
  psfp_pkg::desc_t               q_head;
  psfp_pkg::out_item_t           item;

  assign in_ch.ready = front_ready;

  // Byte parser and word writer.
  psfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (front_ready),
    .rx_byte   (in_ch.rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .done      (done),
    .rel       (rel)
  );

  // Two-bank word buffer.
  psfp_ram #(.WIDTH(psfp_pkg::WORD_W), .DEPTH(2 ** ADDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Completed frames waiting for read-out.
  psfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (done),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Word read-out and output buffer.
  psfp_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .rel        (rel),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (item)
  );

  assign out_ch.word_index  = item.word_index;
  assign out_ch.word_value  = item.word_value;
  assign out_ch.checksum_ok = item.checksum_ok;
  assign out_ch.last        = item.last;

endmodule

// File: rtl/psfp_checker.sv
`include "assert_macros.svh"

module psfp_checker #(
  parameter int FRAME_BYTES = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [psfp_pkg::WORD_IDX_W-1:0] out_word_index,
  input logic [psfp_pkg::WORD_W-1:0]     out_word_value,
  input logic                            out_checksum_ok,
  input logic                            out_last
);

  localparam int DATA_WORDS = (FRAME_BYTES - 4) / 2;
  localparam logic [psfp_pkg::WORD_IDX_W-1:0] LAST_IDX =
    psfp_pkg::WORD_IDX_W'((DATA_WORDS - 1) % 16);

  logic                                                held;
  logic [psfp_pkg::WORD_IDX_W+psfp_pkg::WORD_W+1:0]    out_bundle;

  // A word that is offered but not taken, and everything it carries.
  assign held       = out_valid && !out_ready;
  assign out_bundle = {out_word_index, out_word_value, out_checksum_ok, out_last};

  // A stalled word stays offered and unchanged.
  `PSFP_ASSERT(a_out_hold, clk, rst_n, held |=> out_valid)
  `PSFP_ASSERT(a_out_stable, clk, rst_n, held |=> $stable(out_bundle))

  // The word marked last is always the final data word of the frame.
  `PSFP_ASSERT(a_last_index, clk, rst_n, out_valid && out_last |-> out_word_index == LAST_IDX)

  // Reset empties the output buffer.
  `PSFP_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind particle_sensor_frame_parser_top psfp_checker #(.FRAME_BYTES(FRAME_BYTES)) u_psfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_word_index  (out_ch.word_index),
  .out_word_value  (out_ch.word_value),
  .out_checksum_ok (out_ch.checksum_ok),
  .out_last        (out_ch.last)
);

// File: test/tb_particle_sensor_frame_parser_top.sv
`timescale 1ns / 1ps

module tb_particle_sensor_frame_parser_top;

  localparam int FRAME_BYTES = 32;
  localparam int DATA_WORDS  = (FRAME_BYTES - 4) / 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 100;
  localparam logic [psfp_pkg::BYTE_W-1:0] SECOND_BYTE = 8'h4D;

  logic clk;
  logic rst_n;

  psfp_in_if  byte_bus ();
  psfp_out_if word_bus ();

  particle_sensor_frame_parser_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (byte_bus),
    .out_ch(word_bus)
  );

  // Shadow copy of the parser state, advanced on every accepted byte request.
  logic                        frame_open;
  int                          frame_pos;
  logic [psfp_pkg::WORD_W-1:0] sum_acc;
  logic [psfp_pkg::BYTE_W-1:0] hi_byte;
  logic [psfp_pkg::WORD_W-1:0] word_buf [DATA_WORDS];

  // Words that the parser still owes us, oldest first.
  psfp_pkg::out_item_t expected_words [$];

  // Frame under construction for the sender.
  logic [psfp_pkg::BYTE_W-1:0] frame_buf [FRAME_BYTES];

  // Idling controls shared between the test tasks and the two sides.
  bit send_gaps;
  bit sink_stalls;
  int long_hold_left;
  int stall_left;

  // Run statistics.
  int mismatch_count;
  int bytes_sent;
  int frames_done;
  int frames_good;
  int words_checked;
  int input_stall_cycles;
  int cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the shadow parser by one byte and queue any words it releases.
  function automatic void parse_byte(input logic [psfp_pkg::BYTE_W-1:0] b);
    logic [psfp_pkg::WORD_W-1:0] chk_word;
    logic                        sum_ok;
    psfp_pkg::out_item_t         w;
    if (!frame_open) begin
      if (b == psfp_pkg::START_BYTE) begin
        frame_open = 1'b1;
        frame_pos  = 1;
        sum_acc    = {8'h00, b};
      end
      return;
    end
    if (frame_pos < FRAME_BYTES - 2) sum_acc = sum_acc + {8'h00, b};
    // Data bytes pair up high byte first.
    if (frame_pos >= 2 && frame_pos < 2 + 2 * DATA_WORDS) begin
      if (((frame_pos - 2) & 1) == 0) begin
        hi_byte = b;
      end else begin
        word_buf[(frame_pos - 2) >> 1] = {hi_byte, b};
      end
    end
    if (frame_pos == FRAME_BYTES - 2) hi_byte = b;
    // The final byte completes the checksum word and releases the run.
    if (frame_pos >= FRAME_BYTES - 1) begin
      chk_word = {hi_byte, b};
      sum_ok   = (sum_acc == chk_word);
      for (int k = 0; k < DATA_WORDS; k++) begin
        w.word_index  = 4'(k);
        w.word_value  = word_buf[k];
        w.checksum_ok = sum_ok;
        w.last        = (k == DATA_WORDS - 1);
        expected_words.push_back(w);
      end
      frames_done++;
      if (sum_ok) frames_good++;
      frame_open = 1'b0;
      frame_pos  = 0;
      return;
    end
    frame_pos++;
  endfunction

  // One line per mismatch; the count carries on past the print cap.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at word %0d: %s is 0x%0h, expected 0x%0h",
               words_checked, what, got, want);
    end
  endtask

  // Offer one byte request, with an optional gap first, and wait for it to go.
  task automatic send_byte(input logic [psfp_pkg::BYTE_W-1:0] value);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= value;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    parse_byte(value);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop offering bytes and wait until every owed word has come out.
  task automatic wait_for_drain();
    byte_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // A random byte that cannot open a frame.
  function automatic logic [psfp_pkg::BYTE_W-1:0] noise_byte();
    logic [psfp_pkg::BYTE_W-1:0] b;
    do b = 8'($urandom); while (b == psfp_pkg::START_BYTE);
    return b;
  endfunction

  // Fill the frame with a start byte, the given second byte and random data.
  function automatic void randomise_frame(input logic [psfp_pkg::BYTE_W-1:0] second);
    frame_buf[0] = psfp_pkg::START_BYTE;
    frame_buf[1] = second;
    for (int i = 2; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
  endfunction

  function automatic void put_word(input int k, input logic [psfp_pkg::WORD_W-1:0] value);
    frame_buf[2 + 2 * k] = value[15:8];
    frame_buf[3 + 2 * k] = value[7:0];
  endfunction

  // Write the checksum word, spoiled by a non-zero pattern when asked.
  function automatic void seal_frame(input bit good);
    logic [psfp_pkg::WORD_W-1:0] s;
    s = '0;
    for (int i = 0; i < FRAME_BYTES - 2; i++) s = s + {8'h00, frame_buf[i]};
    if (!good) s = s ^ 16'($urandom_range(1, 65535));
    frame_buf[FRAME_BYTES - 2] = s[15:8];
    frame_buf[FRAME_BYTES - 1] = s[7:0];
  endfunction

  task automatic send_frame();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  // Result side: long hold-offs first, then short random stalls.
  initial begin
    word_bus.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(negedge clk);
      if (long_hold_left > 0) begin
        word_bus.ready <= 1'b0;
        long_hold_left--;
      end else if (stall_left > 0) begin
        word_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        word_bus.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Compare every accepted word with the oldest expectation.
  initial begin
    psfp_pkg::out_item_t exp_word;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (byte_bus.valid && !byte_bus.ready) input_stall_cycles++;
        if (word_bus.valid && word_bus.ready) begin
          if (expected_words.size() == 0) begin
            report_mismatch("word with nothing owed, value", word_bus.word_value, 0);
          end else begin
            exp_word = expected_words.pop_front();
            if (word_bus.word_index !== exp_word.word_index)
              report_mismatch("word_index", word_bus.word_index, exp_word.word_index);
            if (word_bus.word_value !== exp_word.word_value)
              report_mismatch("word_value", word_bus.word_value, exp_word.word_value);
            if (word_bus.checksum_ok !== exp_word.checksum_ok)
              report_mismatch("checksum_ok", word_bus.checksum_ok, exp_word.checksum_ok);
            if (word_bus.last !== exp_word.last)
              report_mismatch("last", word_bus.last, exp_word.last);
          end
          words_checked++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d words still owed",
             cycle_count, expected_words.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Bytes that never open a frame must be dropped silently.
  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'h43);
    send_byte(8'hC2);
    send_byte(8'h02);
    send_byte(SECOND_BYTE);
  endtask

  // Hand-built frames: word extremes, bad sums, start bytes inside a frame.
  task automatic test_directed_frames();
    // Well-formed frame with extreme data words and a matching sum.
    randomise_frame(SECOND_BYTE);
    put_word(0, 16'(2 * DATA_WORDS));
    put_word(1, 16'h0000);
    put_word(2, 16'hFFFF);
    put_word(3, 16'h00FF);
    put_word(4, 16'hFF00);
    seal_frame(1'b1);
    send_frame();
    // Second byte is itself a start byte, more start bytes in the data, bad sum.
    randomise_frame(psfp_pkg::START_BYTE);
    frame_buf[4]  = psfp_pkg::START_BYTE;
    frame_buf[9]  = psfp_pkg::START_BYTE;
    frame_buf[FRAME_BYTES - 3] = psfp_pkg::START_BYTE;
    seal_frame(1'b0);
    send_frame();
    // All data bytes high with a zero second byte, matching sum.
    randomise_frame(8'h00);
    for (int i = 2; i < FRAME_BYTES - 2; i++) frame_buf[i] = 8'hFF;
    seal_frame(1'b1);
    send_frame();
  endtask

  // Mostly well-formed frames with random content, some noise and broken starts.
  task automatic test_random_traffic();
    int broken_len;
    for (int f = 0; f < 5; f++) begin
      repeat ($urandom_range(0, 3)) send_byte(noise_byte());
      if ($urandom_range(0, 7) == 0) begin
        // A frame that is cut short; the next one is swallowed into it.
        broken_len = $urandom_range(1, FRAME_BYTES - 2);
        send_byte(psfp_pkg::START_BYTE);
        repeat (broken_len) send_byte(8'($urandom));
      end
      randomise_frame(($urandom_range(0, 3) == 0) ? 8'($urandom) : SECOND_BYTE);
      seal_frame($urandom_range(0, 3) != 0);
      send_frame();
    end
  endtask

  // The result side blocks for a long stretch so both banks fill and the
  // input stalls; then the sender waits for a full drain before going on.
  task automatic test_backpressure();
    send_gaps      = 1'b0;
    long_hold_left = 300;
    for (int f = 0; f < 3; f++) begin
      randomise_frame(SECOND_BYTE);
      seal_frame(1'b1);
      send_frame();
    end
    wait_for_drain();
    randomise_frame(SECOND_BYTE);
    seal_frame(1'($urandom_range(0, 1)));
    send_frame();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_final_burst();
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    for (int f = 0; f < 2; f++) begin
      randomise_frame(SECOND_BYTE);
      seal_frame(f == 0);
      send_frame();
    end
  endtask

  // Main sequence.
  initial begin
    frame_open         = 1'b0;
    frame_pos          = 0;
    sum_acc            = '0;
    hi_byte            = '0;
    mismatch_count     = 0;
    bytes_sent         = 0;
    frames_done        = 0;
    frames_good        = 0;
    words_checked      = 0;
    input_stall_cycles = 0;
    long_hold_left     = 0;
    send_gaps          = 1'b1;
    sink_stalls        = 1'b1;
    byte_bus.valid     = 1'b0;
    byte_bus.rx_byte   = '0;
    rst_n              = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_hunting();
    test_directed_frames();
    test_random_traffic();
    test_backpressure();
    test_final_burst();

    wait_for_drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes forming %0d frames (%0d with a matching sum); %0d words checked.",
             bytes_sent, frames_done, frames_good, words_checked);
    $display("Input was held off for %0d cycles; %0d mismatches in %0d cycles.",
             input_stall_cycles, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
